// ===== src/sdr_pkg.sv =====
`timescale 1ns / 1ps
package sdr_pkg;

  // Width of the common saturation datapath; holds every intermediate
  localparam int unsigned SatW = 128;

  // Clamp a wide signed value to the signed range of the given bit count
  function automatic logic signed [63:0] sat_s(input logic signed [SatW-1:0] v,
                                               input int unsigned bits);
    logic signed [SatW-1:0] mx;
    logic signed [SatW-1:0] mn;
    mx = (SatW'(1) <<< (bits - 1)) - SatW'(1);
    mn = -mx - SatW'(1);
    if (v > mx) begin
      sat_s = mx[63:0];
    end else if (v < mn) begin
      sat_s = mn[63:0];
    end else begin
      sat_s = v[63:0];
    end
  endfunction

endpackage

// ===== src/sdr_isqrt.sv =====
`timescale 1ns / 1ps
module sdr_isqrt #(
  parameter int unsigned RootW = 32,
  parameter int unsigned SideW = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  logic [2*RootW-1:0] rad_i,
  input  logic [SideW-1:0]   side_i,
  output logic               valid_o,
  output logic [RootW-1:0]   root_o,
  output logic [SideW-1:0]   side_o
);

  localparam int unsigned RemW = RootW + 2;

  logic               v_q    [RootW+1];
  logic [RemW-1:0]    rem_q  [RootW+1];
  logic [RootW-1:0]   root_q [RootW+1];
  logic [2*RootW-1:0] rad_q  [RootW+1];
  logic [SideW-1:0]   side_q [RootW+1];

  // Feed the first stage straight from the inputs
  assign v_q[0]    = valid_i;
  assign rem_q[0]  = '0;
  assign root_q[0] = '0;
  assign rad_q[0]  = rad_i;
  assign side_q[0] = side_i;

  // Resolve one root bit per stage, two radicand bits at a time
  for (genvar s = 0; s < RootW; s++) begin : g_stage
    logic [RemW+1:0] raw;
    logic [RemW+1:0] trial;
    logic            fit;

    assign raw   = {rem_q[s], rad_q[s][2*RootW-1 -: 2]};
    assign trial = {2'b00, root_q[s], 2'b01};
    assign fit   = raw >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s+1] <= 1'b0;
      end else if (en_i) begin
        v_q[s+1] <= v_q[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s+1]  <= fit ? RemW'(raw - trial) : RemW'(raw);
        root_q[s+1] <= {root_q[s][RootW-2:0], fit};
        rad_q[s+1]  <= {rad_q[s][2*RootW-3:0], 2'b00};
        side_q[s+1] <= side_q[s];
      end
    end
  end

  assign valid_o = v_q[RootW];
  assign root_o  = root_q[RootW];
  assign side_o  = side_q[RootW];

endmodule

// ===== src/spin_damping_rate.sv =====
`timescale 1ns / 1ps
// Throughput: one transaction per cycle unless a stalled result holds the pipeline; the square-root
//   unit is pipelined one root bit per stage, so a new spin enters every cycle while it advances.
// A stalled result freezes the whole pipeline; nothing is lost or repeated.
// Reset (rst_ni low, asynchronous) clears all valid bits and sets correction_enable to 1.
module spin_damping_rate #(
  parameter int unsigned WORD_WIDTH = 32,
  parameter int unsigned FRAC_BITS  = 24
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic                         cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic signed [WORD_WIDTH-1:0] spin_x_i,
  input  logic signed [WORD_WIDTH-1:0] spin_y_i,
  input  logic signed [WORD_WIDTH-1:0] spin_z_i,
  input  logic signed [WORD_WIDTH-1:0] force_x_i,
  input  logic signed [WORD_WIDTH-1:0] force_y_i,
  input  logic signed [WORD_WIDTH-1:0] force_z_i,
  input  logic                         pinned_i,
  input  logic                         last_spin_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [WORD_WIDTH-1:0] rate_x_o,
  output logic signed [WORD_WIDTH-1:0] rate_y_o,
  output logic signed [WORD_WIDTH-1:0] rate_z_o,
  output logic                         last_out_o
);
  import sdr_pkg::*;

  localparam int unsigned W     = WORD_WIDTH;
  localparam int unsigned PW    = 2 * W;
  localparam int unsigned SideW = 6 * W + 64 + 2;

  logic en;
  logic corr_q;

  // Stage valid bits
  logic a_v_q, b_v_q, c_v_q, l_v_q, d_v_q, e_v_q, f_v_q, g_v_q;
  logic h_v_q, m_v_q, i_v_q, j_v_q, n_v_q, k_v_q, o_v_q;

  // Stage payloads
  logic signed [W-1:0]    a_y_q [3], a_g_q [3];
  logic                   a_pin_q, a_last_q;
  logic signed [PW-1:0]   b_yy_q [3], b_yg_q [3];
  logic signed [W-1:0]    b_y_q [3], b_g_q [3];
  logic                   b_pin_q, b_last_q;
  logic signed [63:0]     c_yy_q, c_yg_q;
  logic signed [W-1:0]    c_y_q [3], c_g_q [3];
  logic                   c_pin_q, c_last_q;
  logic signed [W+31:0]   l_ah_q [3], l_bh_q [3];
  logic signed [W+32:0]   l_al_q [3], l_bl_q [3];
  logic signed [W-1:0]    l_y_q [3];
  logic signed [63:0]     l_yy_q;
  logic                   l_pin_q, l_last_q;
  logic signed [W+63:0]   d_a_q [3], d_b_q [3];
  logic signed [W-1:0]    d_y_q [3];
  logic signed [63:0]     d_yy_q;
  logic                   d_pin_q, d_last_q;
  logic signed [W-1:0]    e_d_q [3], e_y_q [3];
  logic signed [63:0]     e_yy_q;
  logic                   e_pin_q, e_last_q;
  logic signed [PW-1:0]   f_sq_q [3];
  logic signed [W-1:0]    f_d_q [3], f_y_q [3];
  logic signed [63:0]     f_yy_q;
  logic                   f_pin_q, f_last_q;
  logic [PW-1:0]          g_sum_q;
  logic [SideW-1:0]       g_side_q;

  // Square-root unit outputs
  logic                   s_v;
  logic [W-1:0]           s_root;
  logic [SideW-1:0]       s_side;
  logic signed [W-1:0]    s_d [3], s_y [3];
  logic signed [63:0]     s_yy;
  logic                   s_pin, s_last;

  logic signed [W+3:0]    h_c_q;
  logic signed [64:0]     h_om_q;
  logic signed [W-1:0]    h_d_q [3], h_y_q [3];
  logic                   h_pin_q, h_last_q;
  logic signed [W+36:0]   m_ph_q, m_pl_q;
  logic signed [W-1:0]    m_d_q [3], m_y_q [3];
  logic                   m_pin_q, m_last_q;
  logic signed [W+68:0]   i_kp_q;
  logic signed [W-1:0]    i_d_q [3], i_y_q [3];
  logic                   i_pin_q, i_last_q;
  logic signed [63:0]     j_k_q;
  logic signed [W-1:0]    j_d_q [3], j_y_q [3];
  logic                   j_pin_q, j_last_q;
  logic signed [W+31:0]   n_h_q [3];
  logic signed [W+32:0]   n_l_q [3];
  logic signed [W-1:0]    n_d_q [3];
  logic                   n_pin_q, n_last_q;
  logic signed [W+63:0]   k_ky_q [3];
  logic signed [W-1:0]    k_d_q [3];
  logic                   k_pin_q, k_last_q;
  logic signed [W-1:0]    o_r_q [3];
  logic                   o_last_q;

  // Combinational helpers
  logic signed [PW+1:0]   sum_yy, sum_yg;
  logic signed [63:0]     sat_yy, sat_yg, sat_k;
  logic signed [63:0]     sat_d [3], sat_r [3];
  logic signed [W+64:0]   diff [3];
  logic signed [W+64:0]   corr [3];
  logic signed [W-1:0]    rate [3];

  // Advance whenever the output register is free or drained
  assign en         = !(o_v_q && out_stall_i);
  assign in_stall_o = !en;

  // Hold the correction enable
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      corr_q <= 1'b1;
    end else if (cfg_we_i) begin
      corr_q <= cfg_data_i;
    end
  end

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0; b_v_q <= 1'b0; c_v_q <= 1'b0; l_v_q <= 1'b0;
      d_v_q <= 1'b0; e_v_q <= 1'b0; f_v_q <= 1'b0; g_v_q <= 1'b0;
      h_v_q <= 1'b0; m_v_q <= 1'b0; i_v_q <= 1'b0; j_v_q <= 1'b0;
      n_v_q <= 1'b0; k_v_q <= 1'b0; o_v_q <= 1'b0;
    end else if (en) begin
      a_v_q <= in_valid_i; b_v_q <= a_v_q; c_v_q <= b_v_q; l_v_q <= c_v_q;
      d_v_q <= l_v_q; e_v_q <= d_v_q; f_v_q <= e_v_q; g_v_q <= f_v_q;
      h_v_q <= s_v; m_v_q <= h_v_q; i_v_q <= m_v_q; j_v_q <= i_v_q;
      n_v_q <= j_v_q; k_v_q <= n_v_q; o_v_q <= k_v_q;
    end
  end

  // Saturating arithmetic between stages
  always_comb begin
    sum_yy = b_yy_q[0] + b_yy_q[1] + b_yy_q[2];
    sum_yg = b_yg_q[0] + b_yg_q[1] + b_yg_q[2];
    sat_yy = sat_s(SatW'(sum_yy >>> FRAC_BITS), 64);
    sat_yg = sat_s(SatW'(sum_yg >>> FRAC_BITS), 64);
    sat_k  = sat_s(SatW'(i_kp_q >>> FRAC_BITS), 64);
    for (int i = 0; i < 3; i++) begin
      diff[i]  = d_a_q[i] - d_b_q[i];
      sat_d[i] = sat_s(SatW'(diff[i] >>> FRAC_BITS), W);
      corr[i]  = k_d_q[i] + (k_ky_q[i] >>> FRAC_BITS);
      sat_r[i] = sat_s(SatW'(corr[i]), W);
      if (k_pin_q) begin
        rate[i] = '0;
      end else if (corr_q) begin
        rate[i] = sat_r[i][W-1:0];
      end else begin
        rate[i] = k_d_q[i];
      end
    end
  end

  // Unpack the payload that rides along the square-root unit
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s_d[i] = s_side[i*W +: W];
      s_y[i] = s_side[(3+i)*W +: W];
    end
    s_yy   = s_side[6*W +: 64];
    s_pin  = s_side[6*W+64];
    s_last = s_side[6*W+65];
  end

  // Advance the datapath
  always_ff @(posedge clk_i) begin
    if (en) begin
      a_y_q[0] <= spin_x_i;  a_y_q[1] <= spin_y_i;  a_y_q[2] <= spin_z_i;
      a_g_q[0] <= force_x_i; a_g_q[1] <= force_y_i; a_g_q[2] <= force_z_i;
      a_pin_q  <= pinned_i;
      a_last_q <= last_spin_i;

      for (int i = 0; i < 3; i++) begin
        b_yy_q[i] <= a_y_q[i] * a_y_q[i];
        b_yg_q[i] <= a_y_q[i] * a_g_q[i];
        b_y_q[i]  <= a_y_q[i];
        b_g_q[i]  <= a_g_q[i];
      end
      b_pin_q  <= a_pin_q;
      b_last_q <= a_last_q;

      c_yy_q   <= sat_yy;
      c_yg_q   <= sat_yg;
      c_y_q    <= b_y_q;
      c_g_q    <= b_g_q;
      c_pin_q  <= b_pin_q;
      c_last_q <= b_last_q;

      // Split the 64-bit dot products into upper and lower partial products
      for (int i = 0; i < 3; i++) begin
        l_ah_q[i] <= $signed(c_yy_q[63:32]) * c_g_q[i];
        l_al_q[i] <= $signed({1'b0, c_yy_q[31:0]}) * c_g_q[i];
        l_bh_q[i] <= $signed(c_yg_q[63:32]) * c_y_q[i];
        l_bl_q[i] <= $signed({1'b0, c_yg_q[31:0]}) * c_y_q[i];
      end
      l_y_q    <= c_y_q;
      l_yy_q   <= c_yy_q;
      l_pin_q  <= c_pin_q;
      l_last_q <= c_last_q;

      for (int i = 0; i < 3; i++) begin
        d_a_q[i] <= ((W+64)'(l_ah_q[i]) <<< 32) + (W+64)'(l_al_q[i]);
        d_b_q[i] <= ((W+64)'(l_bh_q[i]) <<< 32) + (W+64)'(l_bl_q[i]);
      end
      d_y_q    <= l_y_q;
      d_yy_q   <= l_yy_q;
      d_pin_q  <= l_pin_q;
      d_last_q <= l_last_q;

      for (int i = 0; i < 3; i++) begin
        e_d_q[i] <= sat_d[i][W-1:0];
      end
      e_y_q    <= d_y_q;
      e_yy_q   <= d_yy_q;
      e_pin_q  <= d_pin_q;
      e_last_q <= d_last_q;

      for (int i = 0; i < 3; i++) begin
        f_sq_q[i] <= e_d_q[i] * e_d_q[i];
      end
      f_d_q    <= e_d_q;
      f_y_q    <= e_y_q;
      f_yy_q   <= e_yy_q;
      f_pin_q  <= e_pin_q;
      f_last_q <= e_last_q;

      g_sum_q  <= PW'(f_sq_q[0]) + PW'(f_sq_q[1]) + PW'(f_sq_q[2]);
      g_side_q <= {f_last_q, f_pin_q, f_yy_q, f_y_q[2], f_y_q[1], f_y_q[0],
                   f_d_q[2], f_d_q[1], f_d_q[0]};

      h_c_q    <= (W+4)'(s_root) * (W+4)'(6);
      h_om_q   <= (65'sd1 <<< FRAC_BITS) - 65'(s_yy);
      h_d_q    <= s_d;
      h_y_q    <= s_y;
      h_pin_q  <= s_pin;
      h_last_q <= s_last;

      // Split the gain product into upper and lower partial products
      m_ph_q   <= h_c_q * $signed(h_om_q[64:32]);
      m_pl_q   <= h_c_q * $signed({1'b0, h_om_q[31:0]});
      m_d_q    <= h_d_q;
      m_y_q    <= h_y_q;
      m_pin_q  <= h_pin_q;
      m_last_q <= h_last_q;

      i_kp_q   <= ((W+69)'(m_ph_q) <<< 32) + (W+69)'(m_pl_q);
      i_d_q    <= m_d_q;
      i_y_q    <= m_y_q;
      i_pin_q  <= m_pin_q;
      i_last_q <= m_last_q;

      j_k_q    <= sat_k;
      j_d_q    <= i_d_q;
      j_y_q    <= i_y_q;
      j_pin_q  <= i_pin_q;
      j_last_q <= i_last_q;

      // Split the correction product into upper and lower partial products
      for (int i = 0; i < 3; i++) begin
        n_h_q[i] <= $signed(j_k_q[63:32]) * j_y_q[i];
        n_l_q[i] <= $signed({1'b0, j_k_q[31:0]}) * j_y_q[i];
      end
      n_d_q    <= j_d_q;
      n_pin_q  <= j_pin_q;
      n_last_q <= j_last_q;

      for (int i = 0; i < 3; i++) begin
        k_ky_q[i] <= ((W+64)'(n_h_q[i]) <<< 32) + (W+64)'(n_l_q[i]);
      end
      k_d_q    <= n_d_q;
      k_pin_q  <= n_pin_q;
      k_last_q <= n_last_q;

      o_r_q    <= rate;
      o_last_q <= k_last_q;
    end
  end

  // Magnitude of the damping term, one root bit per stage
  sdr_isqrt #(
    .RootW (W),
    .SideW (SideW)
  ) u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (g_v_q),
    .rad_i   (g_sum_q),
    .side_i  (g_side_q),
    .valid_o (s_v),
    .root_o  (s_root),
    .side_o  (s_side)
  );

  assign out_valid_o = o_v_q;
  assign rate_x_o    = o_r_q[0];
  assign rate_y_o    = o_r_q[1];
  assign rate_z_o    = o_r_q[2];
  assign last_out_o  = o_last_q;

endmodule
